### rtl/core/brws_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants of the byte range work splitter.
// Used by brws_div and byte_range_work_splitter; depends on nothing.
package brws_pkg;

	localparam int VAL_W       = 48;  // offsets and sizes on the ports
	localparam int TOTAL_W     = 56;  // running byte total
	localparam int ALU_W       = 57;  // operand width of the shared adder
	localparam int WID_W       = 5;   // worker index
	localparam int WCNT_W      = 6;   // worker count, 1..32
	localparam int CNT_W       = 16;  // piece counter and file id
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 64;
	localparam int MAX_WORKERS = 32;
	localparam int MAX_RESULTS = 34;
	localparam int NCNT_W      = 6;   // pieces of one beat, up to MAX_RESULTS

	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_MEASURE = 2'd1;
	localparam logic [1:0] CMD_SPLIT   = 2'd2;

	localparam logic REG_NUM_WORKERS = 1'b0;
	localparam logic REG_MIN_PART    = 1'b1;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [CNT_W-1:0] file_id;
		logic [VAL_W-1:0] file_bytes;
		logic [VAL_W-1:0] in_start;
		logic [VAL_W-1:0] in_end;
	} req_t;

	typedef struct packed {
		logic [WID_W-1:0] worker_index;
		logic [CNT_W-1:0] piece_number;
		logic [CNT_W-1:0] out_file_id;
		logic [VAL_W-1:0] out_start;
		logic [VAL_W-1:0] out_end;
		logic [VAL_W-1:0] out_file_bytes;
		logic             last_piece;
	} piece_t;

endpackage

### rtl/core/brws_div.sv
`timescale 1ns / 1ps
// Restoring serial divider: running total by worker count, one quotient bit a cycle.
// Depends on brws_pkg for widths.
module brws_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [brws_pkg::TOTAL_W-1:0]      dividend,
	input  logic [brws_pkg::WCNT_W-1:0]       divisor,
	output logic                              done,
	output logic [brws_pkg::TOTAL_W-1:0]      quotient
);
	localparam int TW    = brws_pkg::TOTAL_W;
	localparam int DW    = brws_pkg::WCNT_W;
	localparam int CNT_W = $clog2(TW);

	logic [TW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             ge;
	logic [DW:0]      trial_sub;

	assign trial     = {rem_q, quo_q[TW-1]};
	assign ge        = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so the low bits always hold it.
			rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[TW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/byte_range_work_splitter.sv
`timescale 1ns / 1ps
// Clear and unused commands end at ST_LEN, measure at ST_MEAS. A split beat whose
// range fits the current worker gets its piece in ST_WHOLE; otherwise states ROOM,
// CLAMP, LIM, POS and REST give the first piece and PCALC, PEMIT each further one,
// all through the one shared adder and comparator. The first split after a clear
// or reset waits in ST_DIV for the serial division. The request side stalls until
// the last piece is in the output register. Reset zeroes all counters, sets
// num_workers to 1 and min_part_bytes to 0, and empties the output register.
module byte_range_work_splitter #(
	parameter int OFFSET_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  brws_pkg::req_t                    req,
	output logic                              piece_valid,
	input  logic                              piece_stall,
	output brws_pkg::piece_t                  piece,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [brws_pkg::ADDR_W-1:0]       paddr,
	input  logic [brws_pkg::DATA_W-1:0]       pwdata,
	output logic [brws_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);
	localparam int VAL_W   = brws_pkg::VAL_W;
	localparam int TOTAL_W = brws_pkg::TOTAL_W;
	localparam int AW      = brws_pkg::ALU_W;
	localparam int WID_W   = brws_pkg::WID_W;
	localparam int WCNT_W  = brws_pkg::WCNT_W;
	localparam int CNT_W   = brws_pkg::CNT_W;
	localparam int NCNT_W  = brws_pkg::NCNT_W;
	localparam int SW      = OFFSET_BITS;
	localparam int VW      = (OFFSET_BITS < VAL_W) ? OFFSET_BITS : VAL_W;
	localparam int LW      = ((OFFSET_BITS > VAL_W) ? OFFSET_BITS : VAL_W) + 1;
	localparam logic [VAL_W-1:0] IN_MASK = {VAL_W{1'b1}} >> (VAL_W - VW);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LEN    = 4'd1;
	localparam logic [3:0] ST_MEAS   = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_SHARE  = 4'd4;
	localparam logic [3:0] ST_SPLIT  = 4'd5;
	localparam logic [3:0] ST_WHOLE  = 4'd6;
	localparam logic [3:0] ST_ROOM   = 4'd7;
	localparam logic [3:0] ST_CLAMP  = 4'd8;
	localparam logic [3:0] ST_LIM    = 4'd9;
	localparam logic [3:0] ST_POS    = 4'd10;
	localparam logic [3:0] ST_REST   = 4'd11;
	localparam logic [3:0] ST_PCALC  = 4'd12;
	localparam logic [3:0] ST_PEMIT  = 4'd13;

	function automatic logic [WID_W-1:0] next_worker(input logic [WID_W-1:0] c,
			input logic [WCNT_W-1:0] w);
		logic [WCNT_W-1:0] c1;
		c1 = {1'b0, c} + 1'b1;
		return (c1 == w) ? '0 : c1[WID_W-1:0];
	endfunction

	// Configuration registers
	logic [WCNT_W-1:0] num_workers_q;
	logic [VAL_W-1:0]  min_part_q;
	logic              cfg_wr;

	// Sequencer and block state
	logic [3:0]         state_q;
	logic [1:0]         cmd_q;
	logic [CNT_W-1:0]   fid_q;
	logic [VAL_W-1:0]   fb_q;
	logic [VAL_W-1:0]   s_q;
	logic [VAL_W-1:0]   e_q;
	logic [VAL_W-1:0]   ps_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SW-1:0]      share_q;
	logic               share_rdy_q;
	logic [WID_W-1:0]   cur_q;
	logic [SW-1:0]      fill_q;
	logic [CNT_W-1:0]   pcnt_q;
	logic [NCNT_W-1:0]  n_q;
	logic [VAL_W-1:0]   take_q;
	logic               room_zero_q;
	logic [LW-1:0]      lim_q;
	logic [VAL_W-1:0]   pos_q;
	logic [VAL_W-1:0]   rem_q;
	logic               fits_q;

	// Output register
	logic              piece_valid_q;
	brws_pkg::piece_t  piece_q;

	// Shared unit
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW:0]   alu_res;
	logic [AW-1:0] cmp_a;
	logic [AW-1:0] cmp_b;
	logic          cmp_lt;

	logic [WCNT_W-1:0]  wcnt;
	logic               out_free;
	logic               emit_en;
	brws_pkg::piece_t   emit_d;
	logic [VAL_W-1:0]   ps_len;
	logic [SW-1:0]      room;
	logic [TOTAL_W-1:0] sh_pick;
	logic [SW-1:0]      sh_new;
	logic [VAL_W-1:0]   pe;
	logic               rest_zero;
	logic               pemit_last;
	logic               div_start;
	logic               div_done;
	logic [TOTAL_W-1:0] div_quo;

	brws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (wcnt),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_workers_q <= WCNT_W'(1);
			min_part_q    <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				brws_pkg::REG_NUM_WORKERS: num_workers_q <= pwdata[WCNT_W-1:0];
				brws_pkg::REG_MIN_PART:    min_part_q    <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			brws_pkg::REG_NUM_WORKERS: prdata = {{(brws_pkg::DATA_W-WCNT_W){1'b0}}, num_workers_q};
			brws_pkg::REG_MIN_PART:    prdata = {{(brws_pkg::DATA_W-VAL_W){1'b0}}, min_part_q};
			default:                   prdata = '0;
		endcase
	end

	// Out-of-range worker counts are clamped into 1..MAX_WORKERS.
	always_comb begin
		if (num_workers_q == '0)
			wcnt = WCNT_W'(1);
		else if (num_workers_q > WCNT_W'(brws_pkg::MAX_WORKERS))
			wcnt = WCNT_W'(brws_pkg::MAX_WORKERS);
		else
			wcnt = num_workers_q;
	end

	// Adder operand selection
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_LEN: begin
				alu_a   = AW'(e_q);
				alu_b   = AW'(s_q);
				alu_sub = 1'b1;
			end
			ST_MEAS: begin
				alu_a = AW'(total_q);
				alu_b = AW'(ps_q);
			end
			ST_SPLIT: begin
				alu_a = AW'(fill_q);
				alu_b = AW'(ps_q);
			end
			ST_ROOM: begin
				alu_a   = AW'(share_q);
				alu_b   = AW'(fill_q);
				alu_sub = 1'b1;
			end
			ST_CLAMP: begin
				alu_a = AW'(min_part_q);
				alu_b = AW'(take_q);
			end
			ST_LIM: begin
				alu_a = AW'(share_q);
				alu_b = (min_part_q == '0) ? AW'(1) : AW'(min_part_q);
			end
			ST_POS: begin
				alu_a = AW'(s_q);
				alu_b = AW'(take_q);
			end
			ST_REST: begin
				alu_a   = AW'(ps_q);
				alu_b   = AW'(take_q);
				alu_sub = 1'b1;
			end
			ST_PCALC: begin
				alu_a   = AW'(rem_q);
				alu_b   = AW'(share_q);
				alu_sub = 1'b1;
			end
			ST_PEMIT: begin
				alu_a = AW'(pos_q);
				alu_b = AW'(take_q);
			end
			default: ;
		endcase
	end

	// For a subtraction the top bit of the result is the borrow.
	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});

	assign room = alu_res[AW] ? '0 : alu_res[SW-1:0];

	// Comparator operand selection
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			ST_SHARE: begin
				cmp_a = AW'(div_quo);
				cmp_b = AW'(min_part_q);
			end
			ST_SPLIT: begin
				cmp_a = AW'(share_q);
				cmp_b = alu_res[AW-1:0];
			end
			ST_ROOM: begin
				cmp_a = AW'(room);
				cmp_b = AW'(ps_q);
			end
			ST_CLAMP: begin
				cmp_a = AW'(ps_q);
				cmp_b = alu_res[AW-1:0];
			end
			ST_PCALC: begin
				cmp_a = AW'(rem_q);
				cmp_b = AW'(lim_q);
			end
			default: ;
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;

	// A range of 0,0 stands for the whole file; a reversed range has no length.
	assign ps_len = (s_q == '0 && e_q == '0) ? fb_q :
			(alu_res[AW] ? '0 : alu_res[VAL_W-1:0]);

	assign sh_pick = cmp_lt ? TOTAL_W'(min_part_q) : div_quo;

	always_comb begin
		if ((sh_pick >> OFFSET_BITS) != '0)
			sh_new = '1;
		else if (sh_pick == '0)
			sh_new = SW'(1);
		else
			sh_new = sh_pick[SW-1:0];
	end

	assign pe         = alu_res[VAL_W-1:0];
	assign rest_zero  = alu_res[VAL_W-1:0] == '0;
	assign pemit_last = (rem_q == '0) || (n_q == NCNT_W'(brws_pkg::MAX_RESULTS - 1));
	assign div_start  = (state_q == ST_LEN) && (cmd_q == brws_pkg::CMD_SPLIT) &&
			!share_rdy_q && (total_q != '0);

	assign out_free = !piece_valid_q || !piece_stall;

	// Piece presented to the output register
	always_comb begin
		emit_en                = 1'b0;
		emit_d.worker_index    = cur_q;
		emit_d.piece_number    = pcnt_q;
		emit_d.out_file_id     = fid_q;
		emit_d.out_file_bytes  = fb_q;
		emit_d.out_start       = s_q;
		emit_d.out_end         = e_q;
		emit_d.last_piece      = 1'b1;
		case (state_q)
			ST_WHOLE: begin
				emit_en = out_free;
			end
			ST_REST: begin
				emit_en           = out_free && !room_zero_q;
				emit_d.out_end    = pos_q;
				emit_d.last_piece = rest_zero;
			end
			ST_PEMIT: begin
				emit_en           = out_free;
				emit_d.out_start  = pos_q;
				// A loop piece covering the whole file is written as 0,0.
				emit_d.out_end    = (pos_q == '0 && pe == fb_q) ? '0 : pe;
				emit_d.last_piece = pemit_last;
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			share_q     <= '0;
			share_rdy_q <= 1'b0;
			cur_q       <= '0;
			fill_q      <= '0;
			pcnt_q      <= '0;
			n_q         <= '0;
		end else begin
			if (emit_en)
				pcnt_q <= pcnt_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (req_valid)
						state_q <= ST_LEN;
				end
				ST_LEN: begin
					case (cmd_q)
						brws_pkg::CMD_CLEAR: begin
							total_q     <= '0;
							share_q     <= '0;
							share_rdy_q <= 1'b0;
							cur_q       <= '0;
							fill_q      <= '0;
							pcnt_q      <= '0;
							state_q     <= ST_IDLE;
						end
						brws_pkg::CMD_MEASURE: state_q <= ST_MEAS;
						brws_pkg::CMD_SPLIT: begin
							if (share_rdy_q)
								state_q <= ST_SPLIT;
							else if (total_q == '0)
								state_q <= ST_IDLE;
							else
								state_q <= ST_DIV;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_MEAS: begin
					total_q <= alu_res[TOTAL_W] ? '1 : alu_res[TOTAL_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_SHARE;
				end
				ST_SHARE: begin
					share_q     <= sh_new;
					share_rdy_q <= 1'b1;
					state_q     <= ST_SPLIT;
				end
				ST_SPLIT: begin
					n_q <= '0;
					if ({1'b0, cur_q} >= wcnt)
						cur_q <= '0;
					if (fb_q == '0) begin
						state_q <= ST_IDLE;
					end else if (ps_q != '0 && !cmp_lt) begin
						fill_q  <= alu_res[SW-1:0];
						state_q <= ST_WHOLE;
					end else begin
						state_q <= ST_ROOM;
					end
				end
				ST_WHOLE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_ROOM: begin
					take_q      <= cmp_lt ? VAL_W'(room) : ps_q;
					room_zero_q <= room == '0;
					state_q     <= ST_CLAMP;
				end
				ST_CLAMP: begin
					// A tail below the minimum part joins the first piece.
					if (!room_zero_q && cmp_lt)
						take_q <= ps_q;
					state_q <= ST_LIM;
				end
				ST_LIM: begin
					lim_q   <= alu_res[LW-1:0];
					state_q <= ST_POS;
				end
				ST_POS: begin
					pos_q   <= alu_res[VAL_W-1:0];
					state_q <= ST_REST;
				end
				ST_REST: begin
					if (room_zero_q || out_free) begin
						rem_q   <= alu_res[VAL_W-1:0];
						cur_q   <= next_worker(cur_q, wcnt);
						fill_q  <= '0;
						if (!room_zero_q)
							n_q <= NCNT_W'(1);
						state_q <= rest_zero ? ST_IDLE : ST_PCALC;
					end
				end
				ST_PCALC: begin
					// Within the loop the fill is always zero, so fitting means rem <= share,
					// and the whole remainder is taken when it is below the limit.
					fits_q  <= alu_res[AW] || (alu_res[AW-1:0] == '0);
					take_q  <= cmp_lt ? rem_q : VAL_W'(share_q);
					rem_q   <= cmp_lt ? '0 : alu_res[VAL_W-1:0];
					state_q <= ST_PEMIT;
				end
				ST_PEMIT: begin
					if (out_free) begin
						pos_q  <= pe;
						n_q    <= n_q + 1'b1;
						fill_q <= fits_q ? SW'(take_q) : '0;
						if (!fits_q)
							cur_q <= next_worker(cur_q, wcnt);
						state_q <= pemit_last ? ST_IDLE : ST_PCALC;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request beat capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			cmd_q <= req.cmd;
			fid_q <= req.file_id;
			fb_q  <= req.file_bytes & IN_MASK;
			s_q   <= req.in_start & IN_MASK;
			e_q   <= req.in_end & IN_MASK;
		end
		if (state_q == ST_LEN)
			ps_q <= ps_len;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			piece_valid_q <= 1'b0;
		else if (emit_en)
			piece_valid_q <= 1'b1;
		else if (!piece_stall)
			piece_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_en)
			piece_q <= emit_d;
	end

	assign req_stall   = state_q != ST_IDLE;
	assign piece_valid = piece_valid_q;
	assign piece       = piece_q;

endmodule
